// ===== design/pab_pkg.sv =====
`default_nettype none

package pab_pkg;

   // fixed field and arithmetic widths
   localparam int POS_BITS     = 32;
   localparam int OFS_MAX_BITS = 32;
   localparam int DIST_BITS    = 34;

   // transaction payloads
   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } pab_req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       keep;
      logic       done_res;
      logic [2:0] status;
   } pab_rsp_type;

   // status codes
   localparam logic [2:0] ST_OK         = 3'd0;
   localparam logic [2:0] ST_NO_MZ      = 3'd1;
   localparam logic [2:0] ST_HDR_SMALL  = 3'd2;
   localparam logic [2:0] ST_NO_PE      = 3'd3;
   localparam logic [2:0] ST_BAD_MAGIC  = 3'd4;
   localparam logic [2:0] ST_CERT_EARLY = 3'd5;
   localparam logic [2:0] ST_TRUNC      = 3'd6;

   // byte classes decided by the front end
   localparam logic [1:0] CLS_KEEP = 2'd0;
   localparam logic [1:0] CLS_DROP = 2'd1;
   localparam logic [1:0] CLS_CERT = 2'd2;

   // signature characters
   localparam logic [7:0] CHAR_M = 8'h4d;
   localparam logic [7:0] CHAR_Z = 8'h5a;
   localparam logic [7:0] CHAR_P = 8'h50;
   localparam logic [7:0] CHAR_E = 8'h45;

   // optional header magic values
   localparam logic [15:0] MAGIC_PE32  = 16'h010b;
   localparam logic [15:0] MAGIC_PE32P = 16'h020b;

   // absolute positions in the image
   localparam logic [POS_BITS-1:0] POS_MZ_END   = 32'h2;
   localparam logic [POS_BITS-1:0] POS_HDR_PTR  = 32'h3c;
   localparam logic [POS_BITS-1:0] POS_HDR_LAST = 32'h3f;
   localparam logic [POS_BITS-1:0] POS_HDR_END  = 32'h40;

   // positions relative to the PE header
   localparam logic signed [DIST_BITS-1:0] DIST_ONE         = 'sh1;
   localparam logic signed [DIST_BITS-1:0] DIST_HDR_MIN     = 'sh40;
   localparam logic signed [DIST_BITS-1:0] REL_PE0          = 'sh0;
   localparam logic signed [DIST_BITS-1:0] REL_PE1          = 'sh1;
   localparam logic signed [DIST_BITS-1:0] REL_MAGIC_LO     = 'sh18;
   localparam logic signed [DIST_BITS-1:0] REL_MAGIC_HI     = 'sh19;
   localparam logic signed [DIST_BITS-1:0] REL_CSUM         = 'sh58;
   localparam logic signed [DIST_BITS-1:0] REL_CSUM_END     = 'sh5c;
   localparam logic signed [DIST_BITS-1:0] REL_DIR_BASE     = 'sh78;
   localparam logic signed [DIST_BITS-1:0] RUN_NARROW       = 'sh20;
   localparam logic signed [DIST_BITS-1:0] RUN_WIDE         = 'sh30;
   localparam logic signed [DIST_BITS-1:0] CERT_ENTRY_BYTES = 'sh8;
   localparam logic signed [DIST_BITS-1:0] CERT_ENTRY_LAST  = 'sh7;
   localparam logic signed [DIST_BITS-1:0] CREL_NARROW      = REL_DIR_BASE + RUN_NARROW;
   localparam logic signed [DIST_BITS-1:0] CREL_WIDE        = REL_DIR_BASE + RUN_WIDE;
   localparam logic [2:0]                  CERT_LAST_IDX    = 3'd7;

   // classified byte handed from front end to back end
   typedef struct packed {
      logic [7:0]                  data_byte;
      logic                        last_byte;
      logic [2:0]                  ev_code;
      logic [1:0]                  cls;
      logic                        at_e_end;
      logic                        trunc_base;
      logic                        co_nz;
      logic signed [DIST_BITS-1:0] cd;
      logic signed [DIST_BITS-1:0] cdp1;
   } pab_entry_type;

   localparam int ENTRY_BITS = $bits(pab_entry_type);

   // queue between front and back
   localparam int Q_DEPTH    = 2;
   localparam int Q_PTR_BITS = $clog2(Q_DEPTH);
   localparam int Q_CNT_BITS = $clog2(Q_DEPTH + 1);

endpackage

`default_nettype wire

// ===== design/pe_authenticode_byte_filter.sv =====
// Path: an accepted byte is written into the queue, then moved into the output register
//   that drives rsp, where the receiver takes it.
// Throughput: one byte per cycle, sustained while neither side stalls; the front end's
//   single position update per byte sets that figure. A two-entry queue lets either side
//   stall on its own.
// Reset: synchronous, active high; clears the queue pointers, the result valid and all
//   per-image state. No clearing pass: the block takes bytes on the first cycle after reset.
`default_nettype none

module pe_authenticode_byte_filter
   import pab_pkg::*;
#(
   parameter int OFFSET_BITS = 32
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  pab_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output pab_rsp_type rsp_data
);

   localparam int QDATA_BITS = ENTRY_BITS + OFFSET_BITS;

   logic                   push;
   logic                   pop;
   logic                   q_full;
   logic                   q_valid;
   logic [QDATA_BITS-1:0]  q_head;
   pab_entry_type          f_entry;
   logic [OFFSET_BITS-1:0] f_cl;
   pab_entry_type          h_entry;
   logic [OFFSET_BITS-1:0] h_cl;

   // accept a transaction whenever the queue has room
   assign req_stall = q_full;
   assign push      = req_valid && !req_stall;

   // Front end: track the byte position, capture the header offset, optional-header
   // magic and certificate directory entry, and classify each byte against them.
   pab_front #(
      .OFFSET_BITS (OFFSET_BITS)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .advance  (push),
      .req_data (req_data),
      .entry    (f_entry),
      .entry_cl (f_cl)
   );

   // Hold classified bytes so the front keeps taking transactions while the
   // result channel stalls.
   pab_queue #(
      .DATA_BITS (QDATA_BITS)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_data  ({f_cl, f_entry}),
      .pop        (pop),
      .head_valid (q_valid),
      .head_data  (q_head),
      .full       (q_full)
   );

   assign h_entry = q_head[ENTRY_BITS-1:0];
   assign h_cl    = q_head[QDATA_BITS-1:ENTRY_BITS];

   // Back end: resolve the certificate table bounds, keep the sticky status and
   // drive the registered result.
   pab_back #(
      .OFFSET_BITS (OFFSET_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (q_valid),
      .head       (h_entry),
      .head_cl    (h_cl),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

endmodule

`default_nettype wire

// ===== design/pab_front.sv =====
`default_nettype none

module pab_front
   import pab_pkg::*;
#(
   parameter int OFFSET_BITS = 32
)
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   advance,
   input  pab_req_type            req_data,
   output pab_entry_type          entry,
   output logic [OFFSET_BITS-1:0] entry_cl
);

   logic [POS_BITS-1:0]         pos_ff, pos_in;
   logic [OFFSET_BITS-1:0]      hdr_ff, hdr_in;
   logic [OFFSET_BITS-1:0]      co_ff, co_in;
   logic [OFFSET_BITS-1:0]      cl_ff, cl_in;
   logic signed [DIST_BITS-1:0] hd_ff, hd_in;
   logic signed [DIST_BITS-1:0] cd_ff, cd_in;
   logic [7:0]                  magic_lo_ff, magic_lo_in;
   logic                        wide_ff, wide_in;

   logic [7:0]                  b;
   logic                        past, inc, hdr_win, in_win, at_e_end;
   logic [2:0]                  k;
   logic [OFS_MAX_BITS-1:0]     hdr_sh, cert_sh;
   logic [OFFSET_BITS-1:0]      h_new, co_new, cl_new;
   logic signed [DIST_BITS-1:0] crel, pos_x, pos_p1_x, co_x, h_x, cd_cur, cdp1_cur;
   logic [15:0]                 magic_full;
   logic                        e1, e2, e3, e4;
   logic [2:0]                  ev_code;
   logic [1:0]                  cls;

   assign b       = req_data.data_byte;
   assign past    = pos_ff >= POS_HDR_END;
   assign inc     = pos_ff != '1;
   assign hdr_win = pos_ff[POS_BITS-1:2] == POS_HDR_PTR[POS_BITS-1:2];
   assign hdr_sh  = {{(OFS_MAX_BITS-8){1'b0}}, b} << {pos_ff[1:0], 3'b000};
   assign h_new   = hdr_win ? (hdr_ff | hdr_sh[OFFSET_BITS-1:0]) : hdr_ff;

   // certificate directory entry: eight bytes starting on a multiple of eight
   assign crel     = wide_ff ? CREL_WIDE : CREL_NARROW;
   assign in_win   = past && (hd_ff[DIST_BITS-1:3] == crel[DIST_BITS-1:3]);
   assign k        = hd_ff[2:0];
   assign cert_sh  = {{(OFS_MAX_BITS-8){1'b0}}, b} << {k[1:0], 3'b000};
   assign co_new   = (in_win && !k[2]) ? (co_ff | cert_sh[OFFSET_BITS-1:0]) : co_ff;
   assign cl_new   = (in_win && k[2]) ? (cl_ff | cert_sh[OFFSET_BITS-1:0]) : cl_ff;
   assign at_e_end = in_win && (k == CERT_LAST_IDX);

   assign pos_x    = {{(DIST_BITS-POS_BITS){1'b0}}, pos_ff};
   assign pos_p1_x = pos_x + DIST_ONE;
   assign co_x     = {{(DIST_BITS-OFFSET_BITS){1'b0}}, co_ff};
   assign h_x      = {{(DIST_BITS-OFFSET_BITS){1'b0}}, h_new};

   // distance to the certificate table start, seeded when the entry completes
   assign cd_cur   = at_e_end ? (pos_x - co_x) : cd_ff;
   assign cdp1_cur = at_e_end ? (pos_p1_x - co_x) : (cd_ff + DIST_ONE);

   assign magic_full = {b, magic_lo_ff};

   assign e1 = (pos_ff < POS_MZ_END) && (b != (pos_ff[0] ? CHAR_Z : CHAR_M));
   assign e2 = (pos_ff == POS_HDR_LAST) && (h_x < DIST_HDR_MIN);
   assign e3 = past && (((hd_ff == REL_PE0) && (b != CHAR_P)) ||
                        ((hd_ff == REL_PE1) && (b != CHAR_E)));
   assign e4 = past && (hd_ff == REL_MAGIC_HI) &&
               (magic_full != MAGIC_PE32) && (magic_full != MAGIC_PE32P);

   always_comb begin
      priority if (e1) begin
         ev_code = ST_NO_MZ;
      end else if (e2) begin
         ev_code = ST_HDR_SMALL;
      end else if (e3) begin
         ev_code = ST_NO_PE;
      end else if (e4) begin
         ev_code = ST_BAD_MAGIC;
      end else begin
         ev_code = ST_OK;
      end
   end

   always_comb begin
      priority if (!past || (hd_ff < REL_CSUM)) begin
         cls = CLS_KEEP;
      end else if (hd_ff < REL_CSUM_END) begin
         cls = CLS_DROP;
      end else if (hd_ff < crel) begin
         cls = CLS_KEEP;
      end else if (hd_ff < (crel + CERT_ENTRY_BYTES)) begin
         cls = CLS_DROP;
      end else begin
         cls = CLS_CERT;
      end
   end

   always_comb begin
      entry.data_byte  = b;
      entry.last_byte  = req_data.last_byte;
      entry.ev_code    = ev_code;
      entry.cls        = cls;
      entry.at_e_end   = at_e_end;
      entry.trunc_base = !past || (hd_ff < (crel + CERT_ENTRY_LAST));
      entry.co_nz      = co_ff != '0;
      entry.cd         = cd_cur;
      entry.cdp1       = cdp1_cur;
   end

   assign entry_cl = cl_new;

   always_comb begin
      pos_in      = pos_ff;
      hdr_in      = hdr_ff;
      hd_in       = hd_ff;
      magic_lo_in = magic_lo_ff;
      wide_in     = wide_ff;
      co_in       = co_ff;
      cl_in       = cl_ff;
      cd_in       = cd_ff;
      if (advance) begin
         if (req_data.last_byte) begin
            // start over for the next image
            pos_in      = '0;
            hdr_in      = '0;
            hd_in       = '0;
            magic_lo_in = '0;
            wide_in     = 1'b0;
            co_in       = '0;
            cl_in       = '0;
            cd_in       = '0;
         end else begin
            if (inc) begin
               pos_in = pos_ff + POS_BITS'(1);
            end
            hdr_in = h_new;
            if (pos_ff == POS_HDR_LAST) begin
               hd_in = DIST_HDR_MIN - h_x;
            end else if (inc) begin
               hd_in = hd_ff + DIST_ONE;
            end
            if (past && (hd_ff == REL_MAGIC_LO)) begin
               magic_lo_in = b;
            end
            if (past && (hd_ff == REL_MAGIC_HI)) begin
               wide_in = magic_full == MAGIC_PE32P;
            end
            co_in = co_new;
            cl_in = cl_new;
            cd_in = inc ? cdp1_cur : cd_cur;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff      <= '0;
         hdr_ff      <= '0;
         hd_ff       <= '0;
         magic_lo_ff <= '0;
         wide_ff     <= 1'b0;
         co_ff       <= '0;
         cl_ff       <= '0;
         cd_ff       <= '0;
      end else begin
         pos_ff      <= pos_in;
         hdr_ff      <= hdr_in;
         hd_ff       <= hd_in;
         magic_lo_ff <= magic_lo_in;
         wide_ff     <= wide_in;
         co_ff       <= co_in;
         cl_ff       <= cl_in;
         cd_ff       <= cd_in;
      end
   end

endmodule

`default_nettype wire

// ===== design/pab_queue.sv =====
`default_nettype none

module pab_queue
   import pab_pkg::*;
#(
   parameter int DATA_BITS = 96
)
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  logic [DATA_BITS-1:0] push_data,
   input  logic                 pop,
   output logic                 head_valid,
   output logic [DATA_BITS-1:0] head_data,
   output logic                 full
);

   logic [DATA_BITS-1:0]  slot_ff [Q_DEPTH];
   logic [Q_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [Q_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [Q_CNT_BITS-1:0] count_ff, count_in;

   assign head_valid = count_ff != '0;
   assign full       = count_ff == Q_CNT_BITS'(Q_DEPTH);
   assign head_data  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == Q_PTR_BITS'(Q_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == Q_PTR_BITS'(Q_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

// ===== design/pab_back.sv =====
`default_nettype none

module pab_back
   import pab_pkg::*;
#(
   parameter int OFFSET_BITS = 32
)
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   head_valid,
   input  pab_entry_type          head,
   input  logic [OFFSET_BITS-1:0] head_cl,
   output logic                   pop,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output pab_rsp_type            rsp_data
);

   logic [2:0]                  err_ff, err_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   pab_rsp_type                 rsp_data_ff, rsp_data_in;

   logic signed [DIST_BITS-1:0] cl_x;
   logic                        cd_pos, in_cert, ev5, trunc, keep_class;
   logic [2:0]                  status;

   assign cl_x    = {{(DIST_BITS-OFFSET_BITS){1'b0}}, head_cl};
   assign cd_pos  = !head.cd[DIST_BITS-1];
   assign in_cert = head.co_nz && cd_pos && ($signed(head.cd) < cl_x);
   assign ev5     = head.at_e_end && head.co_nz && cd_pos;
   assign trunc   = head.last_byte &&
                    (head.trunc_base || (head.co_nz && ($signed(head.cdp1) < cl_x)));

   // first failure in an image wins and holds until its last byte
   always_comb begin
      priority if (err_ff != ST_OK) begin
         status = err_ff;
      end else if (head.ev_code != ST_OK) begin
         status = head.ev_code;
      end else if (ev5) begin
         status = ST_CERT_EARLY;
      end else if (trunc) begin
         status = ST_TRUNC;
      end else begin
         status = ST_OK;
      end
   end

   assign keep_class = (head.cls == CLS_KEEP) || ((head.cls == CLS_CERT) && !in_cert);

   assign pop = head_valid && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      err_in       = err_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (pop) begin
         err_in               = head.last_byte ? ST_OK : status;
         rsp_valid_in         = 1'b1;
         rsp_data_in.out_byte = head.data_byte;
         rsp_data_in.keep     = keep_class && (status == ST_OK);
         rsp_data_in.done_res = head.last_byte;
         rsp_data_in.status   = status;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         err_ff       <= ST_OK;
         rsp_valid_ff <= 1'b0;
      end else begin
         err_ff       <= err_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

// ===== design/pab_checker.sv =====
`default_nettype none

module pab_checker
   import pab_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input pab_rsp_type rsp_data
);

   logic       rsp_take;
   logic [2:0] err_ff, err_in;
   logic       first_ff, first_in;

   assign rsp_take = rsp_valid && !rsp_stall;

   // track the status carried forward within the current image
   always_comb begin
      err_in   = err_ff;
      first_in = first_ff;
      if (rsp_take) begin
         err_in   = rsp_data.done_res ? ST_OK : rsp_data.status;
         first_in = rsp_data.done_res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         err_ff   <= ST_OK;
         first_ff <= 1'b1;
      end else begin
         err_ff   <= err_in;
         first_ff <= first_in;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed or dropped");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_keep_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.keep |-> rsp_data.status == ST_OK)
      else $error("byte kept under a failing status");

   a_sticky: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (err_ff != ST_OK) |-> (rsp_data.status == err_ff) && !rsp_data.keep)
      else $error("failure status not held for the rest of the image");

   a_mz: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && first_ff && (rsp_data.out_byte != CHAR_M) |->
         rsp_data.status == ST_NO_MZ)
      else $error("missing MZ not flagged on the first byte");

endmodule

bind pe_authenticode_byte_filter pab_checker u_checker (.*);

`default_nettype wire

// ===== sim/tb_pe_authenticode_byte_filter.sv =====
`timescale 1ns / 1ps

module tb_pe_authenticode_byte_filter;
   import pab_pkg::*;

   localparam int OFFSET_BITS = 32;

   // run length and pressure knobs
   localparam int RAND_ITEMS   = 1750;
   localparam int HOLD_CYCLES  = 400;
   localparam int DRAIN_CYCLES = 20;
   localparam int LIMIT_CYCLES = 250000;

   // image layout, relative to file start or to the PE header
   localparam longint unsigned HDR_PTR    = 'h3c;
   localparam longint unsigned HDR_END    = 'h40;
   localparam longint unsigned MAGIC_REL  = 'h18;
   localparam longint unsigned CSUM_REL   = 'h58;
   localparam longint unsigned DIR_BASE   = 'h78;
   localparam longint unsigned NARROW_RUN = 'h20;
   localparam longint unsigned WIDE_RUN   = 'h30;
   localparam logic [31:0]     OFS_MASK   = 32'((64'd1 << OFFSET_BITS) - 64'd1);

   // one row of the directed table: stimulus plus an optional hand-written answer
   typedef struct packed {
      logic [7:0]  b;
      logic        last;
      logic        typed;
      pab_rsp_type exp;
   } dir_row_type;

   localparam int DIR_ROWS = 17;
   localparam pab_rsp_type NO_ANSWER = pab_rsp_type'(0);

   localparam dir_row_type DIR_TAB [DIR_ROWS] = '{
      // a lone byte right after reset is too short an image
      {CHAR_M, 1'b1, 1'b1, {CHAR_M, 1'b0, 1'b1, ST_TRUNC}},
      {8'h00,  1'b1, 1'b1, {8'h00,  1'b0, 1'b1, ST_NO_MZ}},
      {8'hff,  1'b1, 1'b1, {8'hff,  1'b0, 1'b1, ST_NO_MZ}},
      // good signature, then an early end
      {CHAR_M, 1'b0, 1'b1, {CHAR_M, 1'b1, 1'b0, ST_OK}},
      {CHAR_Z, 1'b0, 1'b1, {CHAR_Z, 1'b1, 1'b0, ST_OK}},
      {8'hff,  1'b1, 1'b1, {8'hff,  1'b0, 1'b1, ST_TRUNC}},
      // bad second signature byte sticks until the end
      {CHAR_M, 1'b0, 1'b1, {CHAR_M, 1'b1, 1'b0, ST_OK}},
      {CHAR_M, 1'b0, 1'b1, {CHAR_M, 1'b0, 1'b0, ST_NO_MZ}},
      {8'h00,  1'b0, 1'b1, {8'h00,  1'b0, 1'b0, ST_NO_MZ}},
      {8'hff,  1'b1, 1'b1, {8'hff,  1'b0, 1'b1, ST_NO_MZ}},
      // signature in the wrong order
      {CHAR_Z, 1'b0, 1'b1, {CHAR_Z, 1'b0, 1'b0, ST_NO_MZ}},
      {CHAR_M, 1'b1, 1'b1, {CHAR_M, 1'b0, 1'b1, ST_NO_MZ}},
      // a short well-signed image, judged by the predictor
      {CHAR_M, 1'b0, 1'b0, NO_ANSWER},
      {CHAR_Z, 1'b0, 1'b0, NO_ANSWER},
      {8'h80,  1'b0, 1'b0, NO_ANSWER},
      {8'h7f,  1'b0, 1'b0, NO_ANSWER},
      {8'h01,  1'b1, 1'b0, NO_ANSWER}
   };

   // shapes of generated images
   typedef enum int {
      IMG_GOOD,
      IMG_NOCERT,
      IMG_TRUNC,
      IMG_CERT_EARLY,
      IMG_NO_PE,
      IMG_BAD_MAGIC,
      IMG_HDR_SMALL,
      IMG_NOISE,
      IMG_KINDS
   } img_kind_type;

   logic        clock;
   logic        reset     = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   pab_req_type req_data  = pab_req_type'(0);
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   pab_rsp_type rsp_data;

   // predictor state for the image in flight
   logic [31:0] pos_r = '0;
   logic [31:0] hdr_r = '0;
   logic [15:0] mag_r = '0;
   logic [31:0] co_r  = '0;
   logic [31:0] cl_r  = '0;
   logic [2:0]  err_r = ST_OK;

   pab_rsp_type verdict_q [$];
   int          bad_cnt = 0;

   // traffic shaping shared between processes
   bit tx_idle   = 1'b0;
   bit rx_idle   = 1'b0;
   bit long_hold = 1'b0;
   bit tx_on     = 1'b0;
   int next_gap  = 0;

   // image under construction
   logic [7:0] img [0:511];
   int         img_len;

   pe_authenticode_byte_filter #(
      .OFFSET_BITS(OFFSET_BITS)
   ) uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // stop a hung run
   initial begin : watchdog
      int cyc;
      cyc = 0;
      while (cyc < LIMIT_CYCLES) begin
         @(posedge clock);
         cyc++;
      end
      $display("Simulation FAILED");
      $finish;
   end

   function automatic longint unsigned dir_span();
      return (mag_r == MAGIC_PE32P) ? WIDE_RUN : NARROW_RUN;
   endfunction

   // Decide keep/status for one byte and advance the image state.
   function automatic pab_rsp_type classify_byte(input pab_req_type item);
      logic [7:0]      b;
      longint unsigned p, h, c, e, cend, k;
      bit              region;
      pab_rsp_type     r;
      b      = item.data_byte;
      p      = pos_r;
      region = 1'b0;
      // once an error is latched nothing is inspected any more
      if (err_r == ST_OK) begin
         if (p < 2 && b != ((p == 0) ? CHAR_M : CHAR_Z)) err_r = ST_NO_MZ;
         // gather the little-endian header offset
         if (p >= HDR_PTR && p < HDR_END) begin
            hdr_r = hdr_r | (32'(b) << ((p - HDR_PTR) * 8));
            if (p == HDR_END - 1) begin
               hdr_r = hdr_r & OFS_MASK;
               if (hdr_r < HDR_END && err_r == ST_OK) err_r = ST_HDR_SMALL;
            end
         end
         h = hdr_r;
         c = h + DIR_BASE + dir_span();
         e = c + 8;
         if (p >= HDR_END && err_r == ST_OK) begin
            if ((p == h && b != CHAR_P) || (p == h + 1 && b != CHAR_E)) err_r = ST_NO_PE;
            if (p == h + MAGIC_REL) mag_r = {8'h00, b};
            if (p == h + MAGIC_REL + 1) begin
               mag_r[15:8] = b;
               if (mag_r != MAGIC_PE32P && mag_r != MAGIC_PE32 && err_r == ST_OK)
                  err_r = ST_BAD_MAGIC;
            end
            // the directory run may just have changed with the magic
            c = h + DIR_BASE + dir_span();
            e = c + 8;
            if (p >= c && p < e) begin
               k = p - c;
               if (k < 4) co_r = co_r | (32'(b) << (k * 8));
               else       cl_r = cl_r | (32'(b) << ((k - 4) * 8));
               if (p == e - 1) begin
                  co_r = co_r & OFS_MASK;
                  cl_r = cl_r & OFS_MASK;
                  if (co_r != 0 && 64'(co_r) < e && err_r == ST_OK) err_r = ST_CERT_EARLY;
               end
            end
         end
         cend = 64'(co_r) + 64'(cl_r);
         // drop checksum, certificate entry and the certificate table itself
         if (p < HDR_END || p < h + CSUM_REL)                 region = 1'b1;
         else if (p < h + CSUM_REL + 4)                       region = 1'b0;
         else if (p < c)                                      region = 1'b1;
         else if (p < e)                                      region = 1'b0;
         else if (co_r != 0 && p >= 64'(co_r) && p < cend)    region = 1'b0;
         else                                                 region = 1'b1;
         if (item.last_byte && err_r == ST_OK) begin
            if (p < HDR_END || p + 1 < e || (co_r != 0 && p + 1 < cend)) err_r = ST_TRUNC;
         end
      end
      r.out_byte = b;
      r.keep     = region && (err_r == ST_OK);
      r.done_res = item.last_byte;
      r.status   = err_r;
      // rearm for the next image, or advance with saturation
      if (item.last_byte) begin
         pos_r = '0;
         hdr_r = '0;
         mag_r = '0;
         co_r  = '0;
         cl_r  = '0;
         err_r = ST_OK;
      end else if (pos_r != 32'hffff_ffff) begin
         pos_r = pos_r + 32'd1;
      end
      return r;
   endfunction

   // Offer one byte, wait for the handshake, then log what must come back.
   task automatic put_byte(input pab_req_type item, input bit typed, input pab_rsp_type given);
      pab_rsp_type guess;
      if (next_gap > 0) repeat (next_gap) @(posedge clock);
      req_data  <= item;
      req_valid <= 1'b1;
      tx_on = 1'b1;
      do @(posedge clock); while (req_stall);
      guess = classify_byte(item);
      verdict_q.push_back(typed ? given : guess);
      // draw the gap before the next byte; hold valid when there is none
      next_gap = tx_idle ? $urandom_range(0, 17) : 0;
      if (next_gap > 0) begin
         req_valid <= 1'b0;
         tx_on = 1'b0;
      end
   endtask

   // drop valid before any pause in the byte stream
   task automatic release_tx();
      if (tx_on) begin
         req_valid <= 1'b0;
         tx_on = 1'b0;
      end
   endtask

   task automatic poke(input int at, input logic [31:0] v, input int nb);
      for (int i = 0; i < nb; i++) begin
         if (at + i < img_len) img[at + i] = v[8*i +: 8];
      end
   endtask

   // Build one image of the given shape into img/img_len.
   task automatic build_image(input img_kind_type kind);
      int          h, c, e, full, i;
      logic [15:0] mag;
      logic [31:0] co, cl;
      h   = (kind == IMG_HDR_SMALL) ? $urandom_range(0, 63) : $urandom_range(64, 112);
      mag = $urandom_range(0, 1) ? MAGIC_PE32P : MAGIC_PE32;
      if (kind == IMG_BAD_MAGIC) begin
         mag = $urandom();
         // keep the low byte right half the time so only the high byte fails
         if ($urandom_range(0, 1)) mag[7:0] = MAGIC_PE32[7:0];
         if (mag == MAGIC_PE32 || mag == MAGIC_PE32P) mag = mag ^ 16'h0400;
      end
      c    = h + int'(DIR_BASE) + ((mag == MAGIC_PE32P) ? int'(WIDE_RUN) : int'(NARROW_RUN));
      e    = c + 8;
      co   = e + $urandom_range(0, 40);
      cl   = $urandom_range(1, 24);
      full = int'(co + cl) + $urandom_range(0, 30);
      case (kind)
         IMG_NOCERT: begin
            co   = '0;
            cl   = $urandom();
            full = e + $urandom_range(0, 30);
         end
         IMG_CERT_EARLY: begin
            co   = $urandom_range(1, e - 1);
            full = e + $urandom_range(0, 30);
         end
         IMG_TRUNC: begin
            case ($urandom_range(0, 3))
               0: full = $urandom_range(1, 63);
               1: full = $urandom_range(64, e - 1);
               2: full = $urandom_range(e, int'(co + cl) - 1);
               default: begin
                  // table far past the end, sum may even wrap 32 bits
                  co   = $urandom() | 32'h0100_0000;
                  cl   = $urandom();
                  full = e + $urandom_range(0, 30);
               end
            endcase
         end
         default: ;
      endcase
      case (kind)
         IMG_HDR_SMALL: img_len = 64 + $urandom_range(0, 16);
         IMG_NO_PE:     img_len = h + 2 + $urandom_range(0, 16);
         IMG_BAD_MAGIC: img_len = h + int'(MAGIC_REL) + 2 + $urandom_range(0, 16);
         IMG_NOISE:     img_len = $urandom_range(1, 80);
         default:       img_len = full;
      endcase
      for (i = 0; i < img_len; i++) img[i] = $urandom();
      if (kind == IMG_NOISE) begin
         // pure noise, with a valid signature half the time
         if ($urandom_range(0, 1)) poke(0, {16'h0, CHAR_Z, CHAR_M}, 2);
      end else begin
         poke(0, {16'h0, CHAR_Z, CHAR_M}, 2);
         poke(int'(HDR_PTR), h, 4);
         poke(h, {16'h0, CHAR_E, CHAR_P}, 2);
         poke(h + int'(MAGIC_REL), {16'h0, mag}, 2);
         poke(c, co, 4);
         poke(c + 4, cl, 4);
         if (kind == IMG_NO_PE) begin
            i = h + $urandom_range(0, 1);
            img[i] = img[i] ^ (8'h01 << $urandom_range(0, 7));
         end
      end
   endtask

   // Receiver: random stall before each result, or one long hold on request.
   initial begin : rsp_side
      int n;
      forever begin
         if (long_hold) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            long_hold = 1'b0;
            rsp_stall <= 1'b0;
         end else begin
            n = rx_idle ? $urandom_range(0, 17) : 0;
            if (n > 0) begin
               rsp_stall <= 1'b1;
               repeat (n) @(posedge clock);
               rsp_stall <= 1'b0;
            end
         end
         do @(posedge clock); while (!rsp_valid);
      end
   end

   // Compare each accepted result with the oldest expectation.
   always @(posedge clock) begin : rsp_check
      pab_rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (verdict_q.size() == 0) begin
            bad_cnt++;
            if (bad_cnt <= 10)
               $display("unexpected result: byte %h keep %b done %b status %0d",
                        rsp_data.out_byte, rsp_data.keep, rsp_data.done_res, rsp_data.status);
         end else begin
            want = verdict_q.pop_front();
            if (rsp_data.out_byte !== want.out_byte || rsp_data.keep !== want.keep ||
                rsp_data.done_res !== want.done_res || rsp_data.status !== want.status) begin
               bad_cnt++;
               if (bad_cnt <= 10)
                  $display("mismatch: exp byte %h keep %b done %b status %0d, got %h %b %b %0d",
                           want.out_byte, want.keep, want.done_res, want.status,
                           rsp_data.out_byte, rsp_data.keep, rsp_data.done_res,
                           rsp_data.status);
            end
         end
      end
   end

   // Main stimulus: directed table, then whole images of every shape.
   initial begin : stim
      int           k, n_img, nrand, pick;
      img_kind_type kind;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // walk the directed table with random gaps on both sides
      tx_idle = 1'b1;
      rx_idle = 1'b1;
      for (k = 0; k < DIR_ROWS; k++)
         put_byte(pab_req_type'({DIR_TAB[k].b, DIR_TAB[k].last}), DIR_TAB[k].typed,
                  DIR_TAB[k].exp);

      n_img = 0;
      nrand = 0;
      while (nrand < RAND_ITEMS) begin
         // sweep every shape once, then favor well-formed images
         if (n_img < int'(IMG_KINDS)) begin
            kind = img_kind_type'(n_img);
         end else begin
            pick = $urandom_range(0, 99);
            if      (pick < 60) kind = IMG_GOOD;
            else if (pick < 70) kind = IMG_NOCERT;
            else if (pick < 76) kind = IMG_TRUNC;
            else if (pick < 82) kind = IMG_CERT_EARLY;
            else if (pick < 87) kind = IMG_NO_PE;
            else if (pick < 92) kind = IMG_BAD_MAGIC;
            else if (pick < 96) kind = IMG_HDR_SMALL;
            else                kind = IMG_NOISE;
         end
         // some images run back to back with no idling at all
         tx_idle = ($urandom_range(0, 3) != 0);
         rx_idle = ($urandom_range(0, 3) != 0);
         // back up the block once while bytes keep coming
         if (n_img == 1) long_hold = 1'b1;
         build_image(kind);
         for (k = 0; k < img_len; k++)
            put_byte(pab_req_type'({img[k], 1'(k == img_len - 1)}), 1'b0, NO_ANSWER);
         nrand += img_len;
         n_img++;
         // hold the sender until the block has emptied
         if (n_img == 4 || $urandom_range(0, 5) == 0) begin
            release_tx();
            while (verdict_q.size() != 0) @(posedge clock);
         end
      end

      release_tx();
      while (verdict_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (bad_cnt == 0 && verdict_q.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
